// ===== rtl/pcsf_pkg.sv =====
// ----------------------------------------------------------------------------
// PNG chunk stream filter package
// Shared types and constant tables for the chunk filter front end, command
// queue and byte emitter.
// ----------------------------------------------------------------------------
package pcsf_pkg;

  typedef struct packed {
    logic [30:0] image_width;
    logic [30:0] image_height;
    logic [7:0]  bit_depth;
    logic [7:0]  color_type;
    logic [7:0]  compression_method;
    logic [7:0]  filter_method;
    logic [7:0]  interlace_method;
  } ihdr_t;

  // One queued command: a single byte in data[7:0], or a burst of the eight
  // length and type bytes with the first byte in data[63:56].
  typedef struct packed {
    logic [63:0] data;
    logic        burst;
    logic        last;
    logic        bad;
    ihdr_t       info;
  } cmd_t;

  localparam int unsigned NumTags = 21;

  localparam logic [7:0] SIG_BYTES [8] = '{
    8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10
  };

  localparam logic [31:0] TAG_IHDR = "IHDR";
  localparam logic [31:0] TAG_IEND = "IEND";
  localparam logic [31:0] TAG_ITXT = "iTXt";

  localparam logic [31:0] KNOWN_TAGS [NumTags] = '{
    "IHDR", "PLTE", "IDAT", "IEND", "bKGD", "cHRM", "dSIG", "eXIf",
    "gAMA", "hIST", "iCCP", "iTXt", "pHYs", "sBIT", "sPLT", "sRGB",
    "sTER", "tEXt", "tIME", "tRNS", "zTXt"
  };

  function automatic logic tag_known(logic [31:0] tag);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NumTags; i++) begin
      if (KNOWN_TAGS[i] == tag) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

// ===== rtl/png_chunk_stream_filter.sv =====
// ----------------------------------------------------------------------------
// PNG chunk stream filter
// Path: an accepted byte is written into the queue, then loaded from the queue
// into the output register, where its transfer is offered. Throughput: one
// input byte per cycle while the queue is not full and one output transfer
// per cycle while the downstream side is ready; the eight-byte burst released
// at a chunk type drains at one byte per cycle, so with the default four-entry
// queue the input stalls after each chunk type that is passed on.
// Reset: rst_ni clears the parser, queue and output register; start of file
// on the input restarts parsing at the signature.
// ----------------------------------------------------------------------------
module png_chunk_stream_filter #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [7:0] data_byte
  input  logic [7:0]   s_axis_tdata_i,
  // [0] start_of_file
  input  logic         s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [7:0] out_byte, [38:8] image_width, [69:39] image_height,
  // [77:70] bit_depth, [85:78] color_type, [93:86] compression_method,
  // [101:94] filter_method, [109:102] interlace_method, [111:110] zero
  output logic [111:0] m_axis_tdata_o,
  output logic         m_axis_tlast_o,
  // [0] bad_chunk
  output logic         m_axis_tuser_o
);
  import pcsf_pkg::*;

  logic  accept;
  logic  push, full, pop, empty;
  cmd_t  push_cmd, head;
  logic [7:0] out_byte;
  ihdr_t info;

  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && !full;

  pcsf_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (s_axis_tdata_i),
    .start_of_file_i (s_axis_tuser_i),
    .push_o          (push),
    .push_cmd_o      (push_cmd)
  );

  pcsf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  pcsf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .head_i     (head),
    .pop_o      (pop),
    .valid_o    (m_axis_tvalid_o),
    .ready_i    (m_axis_tready_i),
    .out_byte_o (out_byte),
    .last_o     (m_axis_tlast_o),
    .bad_o      (m_axis_tuser_o),
    .info_o     (info)
  );

  assign m_axis_tdata_o = {2'b00,
                           info.interlace_method,
                           info.filter_method,
                           info.compression_method,
                           info.color_type,
                           info.bit_depth,
                           info.image_height,
                           info.image_width,
                           out_byte};

endmodule

// ===== rtl/pcsf_front.sv =====
// ----------------------------------------------------------------------------
// PNG chunk stream filter front end
// Parses the incoming byte stream into signature, header, data and CRC
// phases, captures IHDR fields and pushes output commands into the queue.
// ----------------------------------------------------------------------------
module pcsf_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     data_byte_i,
  input  logic           start_of_file_i,
  output logic           push_o,
  output pcsf_pkg::cmd_t push_cmd_o
);
  import pcsf_pkg::*;

  localparam logic [2:0] PhSig  = 3'd0;
  localparam logic [2:0] PhHead = 3'd1;
  localparam logic [2:0] PhData = 3'd2;
  localparam logic [2:0] PhCrc  = 3'd3;
  localparam logic [2:0] PhDone = 3'd4;

  localparam logic [1:0] KindOther = 2'd0;
  localparam logic [1:0] KindIhdr  = 2'd1;
  localparam logic [1:0] KindIend  = 2'd2;

  logic [2:0]  phase_q, phase_d, phase_e;
  logic [30:0] cnt_q, cnt_d, cnt_e, cnt_inc;
  logic [30:0] len_q, len_d;
  logic [63:0] held_q, held_d, held_e, held_sh;
  logic        drop_q, drop_d, drop_e;
  logic [1:0]  kind_q, kind_d, kind_e;
  ihdr_t       info_q, info_d, info_e;
  logic [31:0] tag;

  always_comb begin
    phase_e = start_of_file_i ? PhSig : phase_q;
    cnt_e   = start_of_file_i ? '0 : cnt_q;
    held_e  = start_of_file_i ? '0 : held_q;
    drop_e  = start_of_file_i ? 1'b0 : drop_q;
    kind_e  = start_of_file_i ? KindOther : kind_q;
    info_e  = start_of_file_i ? '0 : info_q;
  end

  assign held_sh = {held_e[55:0], data_byte_i};
  assign cnt_inc = cnt_e + 31'd1;
  assign tag     = held_sh[31:0];

  always_comb begin
    phase_d    = phase_e;
    cnt_d      = cnt_e;
    len_d      = start_of_file_i ? '0 : len_q;
    held_d     = held_e;
    drop_d     = drop_e;
    kind_d     = kind_e;
    info_d     = info_e;
    push_o     = 1'b0;
    push_cmd_o = '0;

    case (phase_e)
      PhSig: begin
        push_o = accept_i;
        push_cmd_o.data = {56'd0, SIG_BYTES[cnt_e[2:0]]};
        if (cnt_e[2:0] == 3'd7) begin
          phase_d = PhHead;
          cnt_d   = '0;
          held_d  = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PhHead: begin
        held_d = held_sh;
        if (cnt_e[2:0] == 3'd7) begin
          if (!tag_known(tag)) begin
            push_o = accept_i;
            push_cmd_o.last = 1'b1;
            push_cmd_o.bad  = 1'b1;
            phase_d = PhDone;
          end else begin
            kind_d = (tag == TAG_IHDR) ? KindIhdr :
                     (tag == TAG_IEND) ? KindIend : KindOther;
            drop_d = (tag == TAG_ITXT);
            push_o = accept_i && (tag != TAG_ITXT);
            push_cmd_o.data  = held_sh;
            push_cmd_o.burst = 1'b1;
            len_d   = held_sh[62:32];
            cnt_d   = '0;
            phase_d = (held_sh[62:32] != '0) ? PhData : PhCrc;
          end
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PhData: begin
        if (kind_e == KindIhdr && cnt_e < 31'd13) begin
          case (cnt_e[3:0])
            4'd0:    info_d.image_width[30:24]  = data_byte_i[6:0];
            4'd1:    info_d.image_width[23:16]  = data_byte_i;
            4'd2:    info_d.image_width[15:8]   = data_byte_i;
            4'd3:    info_d.image_width[7:0]    = data_byte_i;
            4'd4:    info_d.image_height[30:24] = data_byte_i[6:0];
            4'd5:    info_d.image_height[23:16] = data_byte_i;
            4'd6:    info_d.image_height[15:8]  = data_byte_i;
            4'd7:    info_d.image_height[7:0]   = data_byte_i;
            4'd8:    info_d.bit_depth           = data_byte_i;
            4'd9:    info_d.color_type          = data_byte_i;
            4'd10:   info_d.compression_method  = data_byte_i;
            4'd11:   info_d.filter_method       = data_byte_i;
            4'd12:   info_d.interlace_method    = data_byte_i;
            default: info_d = info_e;
          endcase
        end
        push_o = accept_i && !drop_e;
        push_cmd_o.data = {56'd0, data_byte_i};
        if (cnt_inc == len_q) begin
          phase_d = PhCrc;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PhCrc: begin
        push_o = accept_i && !drop_e;
        push_cmd_o.data = {56'd0, data_byte_i};
        push_cmd_o.last = (kind_e == KindIend) && (cnt_e[1:0] == 2'd3);
        if (cnt_e[1:0] == 2'd3) begin
          cnt_d   = '0;
          held_d  = '0;
          phase_d = (kind_e == KindIend) ? PhDone : PhHead;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      default: begin
        phase_d = phase_e;
      end
    endcase

    push_cmd_o.info = info_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSig;
      cnt_q   <= '0;
      len_q   <= '0;
      held_q  <= '0;
      drop_q  <= 1'b0;
      kind_q  <= KindOther;
      info_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      held_q  <= held_d;
      drop_q  <= drop_d;
      kind_q  <= kind_d;
      info_q  <= info_d;
    end
  end

  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhDone && !start_of_file_i) |-> !push_o)
    else $error("front pushed a command after parsing stopped");

  a_sig_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhSig || phase_q == PhHead) |-> (cnt_q < 31'd8))
    else $error("signature or header count out of range");

endmodule

// ===== rtl/pcsf_queue.sv =====
// ----------------------------------------------------------------------------
// PNG chunk stream filter command queue
// Small register queue that decouples the parser from the byte emitter.
// ----------------------------------------------------------------------------
module pcsf_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pcsf_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output pcsf_pkg::cmd_t head_o
);
  import pcsf_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      count_q <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue count exceeds depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from an empty queue");

endmodule

// ===== rtl/pcsf_back.sv =====
// ----------------------------------------------------------------------------
// PNG chunk stream filter byte emitter
// Expands queued commands into output bytes and holds them in the output
// register until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
module pcsf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  pcsf_pkg::cmd_t head_i,
  output logic           pop_o,
  output logic           valid_o,
  input  logic           ready_i,
  output logic [7:0]     out_byte_o,
  output logic           last_o,
  output logic           bad_o,
  output pcsf_pkg::ihdr_t info_o
);
  import pcsf_pkg::*;

  logic       valid_q, valid_d;
  logic [2:0] idx_q, idx_d;
  logic [2:0] sel;
  logic       load;
  logic [7:0] byte_q, byte_d;
  logic       last_q, bad_q;
  ihdr_t      info_q;

  assign load = !valid_q || ready_i;
  assign sel  = 3'd7 - idx_q;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    pop_o   = 1'b0;
    byte_d  = head_i.burst ? head_i.data[{sel, 3'b000} +: 8] : head_i.data[7:0];
    if (load) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        if (head_i.burst && idx_q != 3'd7) begin
          idx_d = idx_q + 3'd1;
        end else begin
          idx_d = '0;
          pop_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !empty_i) begin
      byte_q <= byte_d;
      last_q <= head_i.last;
      bad_q  <= head_i.bad;
      info_q <= head_i.info;
    end
  end

  assign valid_o    = valid_q;
  assign out_byte_o = byte_q;
  assign last_o     = last_q;
  assign bad_o      = bad_q;
  assign info_o     = info_q;

  a_burst_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != 3'd0) |-> (!empty_i && head_i.burst))
    else $error("burst index advanced without a burst command at the head");

  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && bad_q) |-> last_q)
    else $error("error transfer not marked last");

endmodule
